// ===== rtl/lcso_pkg.sv =====
`default_nettype none

package lcso_pkg;

  // Generator constants: state = state * LCG_MUL + LCG_ADD, modulo 2^32.
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;
  localparam logic [31:0] LCG_RESET = 32'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SITE,
    ST_RUN
  } state_t;

  // Control from the sequencer to the generator.
  typedef struct packed {
    logic step;
    logic seed;
  } lcg_ctrl_t;

  // Base64 alphabet lookup: A-Z a-z 0-9 + /
  function automatic logic [6:0] b64_char(input logic [5:0] idx);
    logic [6:0] idx7;
    idx7 = {1'b0, idx};
    if (idx < 6'd26) begin
      b64_char = 7'd65 + idx7;
    end else if (idx < 6'd52) begin
      b64_char = 7'd71 + idx7;
    end else if (idx < 6'd62) begin
      b64_char = idx7 - 7'd4;
    end else if (idx == 6'd62) begin
      b64_char = 7'd43;
    end else begin
      b64_char = 7'd47;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lcso_lcg.sv =====
`default_nettype none

module lcso_lcg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lcso_pkg::lcg_ctrl_t ctrl,
  input  wire logic [7:0]         seed_val,
  output logic      [5:0]         draw6
);
  import lcso_pkg::*;

  logic [31:0] lcg_state;
  logic [31:0] operand;
  logic [31:0] lcg_state_next;

  // When seeding, the character replaces the state before the step.
  always_comb begin
    operand        = ctrl.seed ? {24'd0, seed_val} : lcg_state;
    lcg_state_next = operand * LCG_MUL + LCG_ADD;
  end

  // Only the low six bits of the draw (state bits 21..16) matter downstream.
  assign draw6 = lcg_state_next[21:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state <= LCG_RESET;
    end else if (ctrl.step) begin
      lcg_state <= lcg_state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcg_seeded_char_obfuscator_unit.sv =====
`default_nettype none

// Byte obfuscator: each input item (one byte, or a padding group) becomes
// sixteen base64 characters, delivered as four output items of four
// characters each, with last set on the fourth.
// Input channel: in_valid/in_ready carrying start_req, pad and char_code.
// start_req clears the group position before the item is processed.
// Output channel: out_valid/out_ready carrying c0..c3 and last.
// A single multiply-add generator unit takes one step per cycle under a
// small sequencer, except while it is idle or holds for a stalled receiver.
// A real character costs one site draw plus sixteen character draws; a
// padding group skips the site draw. in_ready is high only while the
// sequencer is idle, so the next item is not taken until the last quad
// of the current one has been built.
// If the receiver stalls, the sequencer holds before the fourth character
// of the next quad until the output register is free, so nothing is lost.
// Synchronous reset sets the generator state to 1, clears the group
// position and empties the output register.
module lcg_seeded_char_obfuscator_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       start_req,
  input  wire logic       pad,
  input  wire logic [7:0] char_code,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [6:0] c0,
  output logic      [6:0] c1,
  output logic      [6:0] c2,
  output logic      [6:0] c3,
  output logic            last
);
  import lcso_pkg::*;

  state_t      state;
  state_t      state_next;
  lcg_ctrl_t   lcg_ctrl;

  // Item context captured at acceptance.
  logic        pad_reg;
  logic [7:0]  char_reg;
  logic [1:0]  group_pos;

  // Sequencer counters: quad and character within the quad.
  logic [1:0]  q;
  logic [1:0]  m;
  logic [1:0]  site;
  logic        site_en;

  // Characters of the quad being built.
  logic [6:0]  buf0;
  logic [6:0]  buf1;
  logic [6:0]  buf2;

  logic [5:0]  draw6;
  logic [5:0]  offset;
  logic [5:0]  offset_prod;
  logic [5:0]  idx;
  logic [6:0]  ch_now;
  logic        at_site;
  logic        run_go;
  logic        quad_done;
  logic        item_done;
  logic        accept;

  lcso_lcg u_lcg (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (lcg_ctrl),
    .seed_val (char_reg),
    .draw6    (draw6)
  );

  assign accept = in_valid && in_ready;

  // The offset 16*group + 4*q + 1 only matters modulo 64, so it is simply
  // the group position, the quad and a low one packed together. At the
  // site quad it is zero. The product is kept modulo 64 as well.
  always_comb begin
    at_site     = site_en && (q == site);
    offset      = at_site ? 6'd0 : {group_pos, q, 2'b01};
    offset_prod = offset * ({4'd0, m} + 6'd1);
    idx         = draw6 + offset_prod;
    ch_now      = b64_char(idx);
  end

  // A quad completes on its fourth character; that step may only happen
  // when the output register can take the quad in the same edge.
  always_comb begin
    quad_done = (m == 2'd3);
    run_go    = (state == ST_RUN) && (!quad_done || !out_valid || out_ready);
    item_done = run_go && quad_done && (q == 2'd3);
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = pad ? ST_RUN : ST_SITE;
        end
      end
      ST_SITE: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (item_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready      = 1'b0;
    lcg_ctrl.step = 1'b0;
    lcg_ctrl.seed = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SITE: begin
        lcg_ctrl.step = 1'b1;
      end
      ST_RUN: begin
        lcg_ctrl.step = run_go;
        lcg_ctrl.seed = run_go && at_site && (m == 2'd0);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_pos <= 2'd0;
      q         <= 2'd0;
      m         <= 2'd0;
      site_en   <= 1'b0;
      site      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (start_req) begin
          group_pos <= 2'd0;
        end
        q       <= 2'd0;
        m       <= 2'd0;
        site_en <= 1'b0;
      end
      if (state == ST_SITE) begin
        site    <= draw6[1:0];
        site_en <= !pad_reg;
      end
      if (run_go) begin
        m <= m + 2'd1;
        if (quad_done) begin
          q <= q + 2'd1;
        end
      end
      if (item_done) begin
        group_pos <= group_pos + 2'd1;
      end
      if (run_go && quad_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      pad_reg  <= pad;
      char_reg <= char_code;
    end
    if (run_go) begin
      case (m)
        2'd0: begin
          buf0 <= ch_now;
        end
        2'd1: begin
          buf1 <= ch_now;
        end
        2'd2: begin
          buf2 <= ch_now;
        end
        default: begin
          c0   <= buf0;
          c1   <= buf1;
          c2   <= buf2;
          c3   <= ch_now;
          last <= (q == 2'd3);
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/lcso_quad_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the obfuscator, predicts the four quads that each
// accepted group must produce and compares every accepted quad with the
// oldest prediction still outstanding.
module lcso_quad_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       start_req,
  input  logic       pad,
  input  logic [7:0] char_code,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [6:0] c0,
  input  logic [6:0] c1,
  input  logic [6:0] c2,
  input  logic [6:0] c3,
  input  logic       last,
  output int         failures,
  output int         pending,
  output int         quads_checked
);
  import lcso_pkg::*;

  typedef struct packed {
    logic [6:0] c0;
    logic [6:0] c1;
    logic [6:0] c2;
    logic [6:0] c3;
    logic       last;
  } quad_t;

  localparam logic [0:511] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [31:0] gen_state;
  logic [1:0]  group_idx;
  quad_t       quad_queue[$];
  int          err_total;
  int          checked_total;

  initial begin
    failures = 0;
    pending = 0;
    quads_checked = 0;
    err_total = 0;
    checked_total = 0;
  end

  // One generator step; the draw is bits 30..16 of the new state.
  task automatic gen_draw(output logic [14:0] draw);
    gen_state = gen_state * LCG_MUL + LCG_ADD;
    draw = gen_state[30:16];
  endtask

  function automatic logic [6:0] alpha_char(input logic [5:0] idx);
    logic [7:0] ascii;
    ascii = B64_ALPHABET[idx * 8 +: 8];
    return ascii[6:0];
  endfunction

  task automatic predict_group(input logic is_start, input logic is_pad,
                               input logic [7:0] ch);
    logic [14:0] draw;
    logic [2:0]  site;
    logic [5:0]  offset;
    logic [6:0]  chars [4];
    quad_t       quad;
    int          q;
    int          m;
    if (is_start) begin
      group_idx = 2'd0;
    end
    site = 3'd4;
    if (!is_pad) begin
      gen_draw(draw);
      site = {1'b0, draw[1:0]};
    end
    for (q = 0; q < 4; q++) begin
      offset = 6'(4 * q + 16 * int'(group_idx) + 1);
      if (site == 3'(q)) begin
        gen_state = {24'd0, ch};
        offset = 6'd0;
      end
      for (m = 1; m <= 4; m++) begin
        gen_draw(draw);
        chars[m - 1] = alpha_char(6'(int'(draw) + int'(offset) * m));
      end
      quad = '{chars[0], chars[1], chars[2], chars[3], (q == 3)};
      quad_queue.push_back(quad);
    end
    group_idx = group_idx + 2'd1;
  endtask

  task automatic report_field(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    err_total++;
  endtask

  always @(posedge clk) begin
    quad_t want;
    if (rst) begin
      gen_state = LCG_RESET;
      group_idx = 2'd0;
      quad_queue.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_group(start_req, pad, char_code);
      end
      if (out_valid && out_ready) begin
        checked_total++;
        if (quad_queue.size() == 0) begin
          $display("%0t: quad with nothing expected, got %h %h %h %h last %b",
                   $time, c0, c1, c2, c3, last);
          err_total++;
        end else begin
          want = quad_queue.pop_front();
          if (c0 !== want.c0) report_field("c0", int'(want.c0), int'(c0));
          if (c1 !== want.c1) report_field("c1", int'(want.c1), int'(c1));
          if (c2 !== want.c2) report_field("c2", int'(want.c2), int'(c2));
          if (c3 !== want.c3) report_field("c3", int'(want.c3), int'(c3));
          if (last !== want.last) report_field("last", int'(want.last), int'(last));
        end
      end
    end
    failures <= err_total;
    pending <= quad_queue.size();
    quads_checked <= checked_total;
  end

endmodule

// ===== tb/sv/tb_lcg_seeded_char_obfuscator_unit.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the obfuscator. The checker beside the block does
// all of the prediction and comparison; this module only produces items,
// pulls results out at an uneven pace and decides the outcome.
module tb_lcg_seeded_char_obfuscator_unit;

  // A group occupies the block only while its draws are made, and each result
  // is held back only by a bounded receiver stall, so reaching STALL_LIMIT
  // without any handshake can only mean the block has hung.
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_GROUPS = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       start_req = 1'b0;
  logic       pad = 1'b0;
  logic [7:0] char_code = 8'd0;
  logic       out_ready = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [6:0] c0;
  wire  [6:0] c1;
  wire  [6:0] c2;
  wire  [6:0] c3;
  wire        last;

  int failures;
  int pending;
  int quads_checked;

  // When calm is set, neither side inserts any gaps, so the block is run
  // back to back for a while.
  bit calm = 1'b0;
  int idle_cycles = 0;
  int n_groups = 0;
  int n_pads = 0;
  int n_starts = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lcg_seeded_char_obfuscator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .start_req (start_req),
    .pad       (pad),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .c0        (c0),
    .c1        (c1),
    .c2        (c2),
    .c3        (c3),
    .last      (last)
  );

  lcso_quad_checker quad_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .start_req     (start_req),
    .pad           (pad),
    .char_code     (char_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .c0            (c0),
    .c1            (c1),
    .c2            (c2),
    .c3            (c3),
    .last          (last),
    .failures      (failures),
    .pending       (pending),
    .quads_checked (quads_checked)
  );

  // Offers one item after a random gap and returns at the edge where it is
  // taken. With no gap, valid simply stays high and only the payload moves
  // on, so valid is never lowered and raised within the same step.
  task automatic send_group(input logic is_start, input logic is_pad,
                            input logic [7:0] ch);
    int gap;
    gap = calm ? 0 : $urandom_range(6, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_req <= is_start;
    pad <= is_pad;
    char_code <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_groups++;
    if (is_pad) n_pads++;
    if (is_start) n_starts++;
  endtask

  // Holds the sender back until every predicted quad has been delivered.
  // The wait before the loop lets the checker's count take in the item just accepted.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: for every result it draws a stall, then holds ready high until
  // a quad is taken.
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(6, 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles at %0t", idle_cycles, $time);
        $display("tb_lcg_seeded_char_obfuscator_unit: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int msg_len;
    int pad_len;
    int i;
    bit paused_mid;
    paused_mid = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A zero byte is a real character that seeds the
    // generator with zero, so it opens the run straight after reset.
    send_group(1'b1, 1'b0, 8'h00);
    send_group(1'b0, 1'b0, 8'hFF);
    send_group(1'b0, 1'b0, 8'h80);
    send_group(1'b0, 1'b0, 8'h01);
    // The fifth and later groups of one message wrap the group position.
    send_group(1'b0, 1'b0, 8'h55);
    send_group(1'b0, 1'b0, 8'hAA);
    send_group(1'b0, 1'b0, 8'h7F);
    send_group(1'b0, 1'b0, 8'h41);
    send_group(1'b0, 1'b0, 8'h00);
    // Padding ignores the byte, so it is given noisy values here.
    send_group(1'b0, 1'b1, 8'hFF);
    send_group(1'b0, 1'b1, 8'h00);
    // Start and padding together: the position is cleared, nothing seeded.
    send_group(1'b1, 1'b1, 8'h3C);
    send_group(1'b0, 1'b0, 8'hC3);
    // Back-to-back starts, including a start on a zero byte.
    send_group(1'b1, 1'b0, 8'h00);
    send_group(1'b1, 1'b0, 8'hFF);
    send_group(1'b1, 1'b1, 8'hA5);
    send_group(1'b0, 1'b1, 8'h5A);
    send_group(1'b0, 1'b0, 8'hFE);

    // Let everything come out before the random part begins.
    wait_drained();

    // Random part: mostly well-formed messages (a start, a few bytes, then
    // up to two padding groups), with the odd stray item as noise. Now and
    // then a message runs with no gaps on either side.
    while (n_groups < RANDOM_GROUPS + 18) begin
      if ($urandom_range(9, 0) == 0) begin
        calm = 1'b0;
        send_group(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                   8'($urandom_range(255, 0)));
      end else begin
        calm = ($urandom_range(5, 0) == 0);
        msg_len = $urandom_range(8, 1);
        pad_len = $urandom_range(2, 0);
        for (i = 0; i < msg_len; i++) begin
          send_group(i == 0, 1'b0, 8'($urandom_range(255, 0)));
        end
        for (i = 0; i < pad_len; i++) begin
          send_group(1'b0, 1'b1, 8'($urandom_range(255, 0)));
        end
      end
      if (!paused_mid && n_groups >= 160) begin
        paused_mid = 1'b1;
        wait_drained();
      end
    end
    calm = 1'b0;

    wait_drained();
    // Give the block some further cycles to show any stray result before
    // the verdict.
    repeat (40) @(posedge clk);

    $display("covered %0d groups: %0d padding, %0d with a message start",
             n_groups, n_pads, n_starts);
    $display("%0d quads compared, %0d mismatches", quads_checked, failures);
    if (failures == 0) begin
      $display("tb_lcg_seeded_char_obfuscator_unit: done, clean");
    end else begin
      $display("tb_lcg_seeded_char_obfuscator_unit: done, errors");
    end
    $finish;
  end

endmodule
